// ===== rtl/core/vrd_pkg.sv =====
// shared types and codes for the record deframer
package vrd_pkg;

    // phase codes of the front parser
    localparam logic [1:0] PH_LEN_LO = 2'd0;
    localparam logic [1:0] PH_LEN_HI = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_PAD    = 2'd3;

    // result event codes
    localparam logic [2:0] EV_BYTE  = 3'd0;
    localparam logic [2:0] EV_END   = 3'd1;
    localparam logic [2:0] EV_EOS   = 3'd2;
    localparam logic [2:0] EV_TRUNC = 3'd3;
    localparam logic [2:0] EV_OVER  = 3'd4;

    // record class codes
    localparam logic [1:0] CL_DATA    = 2'd0;
    localparam logic [1:0] CL_TRANS   = 2'd1;
    localparam logic [1:0] CL_UNKNOWN = 2'd2;
    localparam logic [1:0] CL_SHORT   = 2'd3;

    // record type bytes and header size of a data record
    localparam logic [7:0]  TYPE_DATA  = 8'd0;
    localparam logic [7:0]  TYPE_TRANS = 8'd13;
    localparam logic [15:0] DATA_HEAD  = 16'd5;

    // command queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // one classified beat passed from front to back
    typedef struct packed {
        logic [2:0]  ev;
        logic [1:0]  cls;
        logic [7:0]  data;
        logic [31:0] base;
        logic [15:0] offset;
        logic        rec_end;
        logic [15:0] plen;
    } vrd_cmd_t;

endpackage

// ===== rtl/core/vlda_record_deframer_unit.sv =====
// top level of the object stream record deframer
//
// input channel: in_valid/in_ready carry one stream byte per beat, or an
// end_of_input beat that carries no byte. output channel: out_valid/out_ready
// carry at most one result beat per input beat (payload byte, record end,
// end of stream, truncation or oversize).
// cfg_write_en/cfg_write_data set the largest accepted record length; write
// only while the block is idle.
// throughput: one input beat per cycle while the queue is not full, set by
// the front parser. a result passes from the front parse into the queue,
// then through the address add into the output register.
// a four-entry command queue sits between the parser and the output register,
// so the input side keeps taking beats while the receiver stalls, until the
// queue is full; in_ready then drops until the receiver takes a beat.
// reset clears the framing state, empties the queue and the output register,
// and sets the length limit to 65535.
module vlda_record_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [1:0]  record_class,
    output logic [7:0]  out_byte,
    output logic [31:0] byte_address,
    output logic        record_end,
    output logic [15:0] payload_length
);
    import vrd_pkg::*;

    logic     accept;
    logic     push;
    vrd_cmd_t push_cmd;
    logic     pop;
    logic     q_full;
    logic     q_not_empty;
    vrd_cmd_t head_cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // framing and classification
    vrd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .accept         (accept),
        .in_byte        (in_byte),
        .end_of_input   (end_of_input),
        .cmd_valid      (push),
        .cmd            (push_cmd)
    );

    // decoupling queue
    vrd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // result formation and output register
    vrd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_not_empty),
        .cmd            (head_cmd),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .record_class   (record_class),
        .out_byte       (out_byte),
        .byte_address   (byte_address),
        .record_end     (record_end),
        .payload_length (payload_length)
    );

endmodule

// ===== rtl/core/vrd_front.sv =====
// front parser: tracks record framing and classifies each input beat
module vrd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [15:0]      cfg_write_data,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             end_of_input,
    output logic             cmd_valid,
    output vrd_pkg::vrd_cmd_t cmd
);
    import vrd_pkg::*;

    logic [15:0] max_len_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] start_reg, start_next;
    logic        skip_reg, skip_next;

    logic [15:0] full_len;
    logic [16:0] count_inc;
    logic        last;
    logic        long_rec;
    logic [7:0]  type_eff;
    logic [1:0]  cls;
    logic [15:0] plen;
    logic        emit;

    // length register, written by the user only while idle (not enforced)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= 16'hFFFF;
        end
        else if (cfg_write_en)
        begin
            max_len_reg <= cfg_write_data;
        end
    end

    // framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN_LO;
            len_reg   <= '0;
            count_reg <= '0;
            type_reg  <= '0;
            start_reg <= '0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            type_reg  <= type_next;
            start_reg <= start_next;
            skip_reg  <= skip_next;
        end
    end

    // body byte helpers
    assign full_len  = {in_byte, len_reg[7:0]};
    assign count_inc = {1'b0, count_reg} + 17'd1;
    assign last      = count_inc >= {1'b0, len_reg};
    assign long_rec  = len_reg >= DATA_HEAD;
    assign type_eff  = (count_reg == 16'd0) ? in_byte : type_reg;

    // class and payload length of the current record
    always_comb
    begin
        if (type_eff == TYPE_DATA)
        begin
            cls = long_rec ? CL_DATA : CL_SHORT;
        end
        else if (type_eff == TYPE_TRANS)
        begin
            cls = CL_TRANS;
        end
        else
        begin
            cls = CL_UNKNOWN;
        end
        case (cls)
            CL_DATA:  plen = len_reg - DATA_HEAD;
            CL_SHORT: plen = 16'd0;
            default:  plen = len_reg - 16'd1;
        endcase
    end

    // next state and command for the accepted beat
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        count_next = count_reg;
        type_next  = type_reg;
        start_next = start_reg;
        skip_next  = skip_reg;
        cmd_valid  = 1'b0;
        cmd        = '0;
        emit       = 1'b0;
        if (accept)
        begin
            if (end_of_input)
            begin
                cmd.ev     = (phase_reg == PH_LEN_LO) ? EV_EOS : EV_TRUNC;
                cmd_valid  = 1'b1;
                phase_next = PH_LEN_LO;
                skip_next  = 1'b0;
                count_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_LEN_LO:
                    begin
                        len_next   = {8'h00, in_byte};
                        phase_next = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        len_next   = full_len;
                        count_next = '0;
                        type_next  = '0;
                        start_next = '0;
                        if (full_len == 16'd0)
                        begin
                            phase_next  = PH_LEN_LO;
                            cmd.ev      = EV_END;
                            cmd.cls     = CL_UNKNOWN;
                            cmd.rec_end = 1'b1;
                            cmd_valid   = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                            if (full_len > max_len_reg)
                            begin
                                skip_next = 1'b1;
                                cmd.ev    = EV_OVER;
                                cmd_valid = 1'b1;
                            end
                            else
                            begin
                                skip_next = 1'b0;
                            end
                        end
                    end
                    PH_PAD:
                    begin
                        phase_next = PH_LEN_LO;
                    end
                    default:
                    begin
                        count_next = count_inc[15:0];
                        if (!skip_reg)
                        begin
                            if (count_reg == 16'd0)
                            begin
                                type_next  = in_byte;
                                start_next = '0;
                            end
                            else if (type_reg == TYPE_DATA)
                            begin
                                if (long_rec)
                                begin
                                    if (count_reg < DATA_HEAD)
                                    begin
                                        // address bytes, least significant first
                                        case (count_reg[2:0])
                                            3'd1:    start_next[7:0]   = in_byte;
                                            3'd2:    start_next[15:8]  = in_byte;
                                            3'd3:    start_next[23:16] = in_byte;
                                            3'd4:    start_next[31:24] = in_byte;
                                            default: start_next        = start_reg;
                                        endcase
                                    end
                                    else
                                    begin
                                        emit       = 1'b1;
                                        cmd.base   = start_reg;
                                        cmd.offset = count_reg - DATA_HEAD;
                                    end
                                end
                            end
                            else if (type_reg == TYPE_TRANS)
                            begin
                                emit = 1'b1;
                            end
                        end
                        if (emit)
                        begin
                            cmd.ev    = EV_BYTE;
                            cmd.data  = in_byte;
                            cmd_valid = 1'b1;
                        end
                        if (last)
                        begin
                            if (!skip_reg)
                            begin
                                cmd.cls     = cls;
                                cmd.rec_end = 1'b1;
                                cmd.plen    = plen;
                                if (!emit)
                                begin
                                    cmd.ev    = EV_END;
                                    cmd_valid = 1'b1;
                                end
                            end
                            skip_next  = 1'b0;
                            phase_next = len_reg[0] ? PH_PAD : PH_LEN_LO;
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/vrd_queue.sv =====
// short command queue between the front parser and the result stage
module vrd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  vrd_pkg::vrd_cmd_t push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output vrd_pkg::vrd_cmd_t head_cmd
);
    import vrd_pkg::*;

    vrd_cmd_t         slot_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;

    assign full      = count_reg == QDEPTH[QAW:0];
    assign not_empty = count_reg != '0;
    assign head_cmd  = slot_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // no write into a full queue without a read in the same cycle
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("command queue overflow");

    // no read from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("command queue underflow");

    // fill count tracks pointer distance
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != QDEPTH[QAW:0]) |-> (count_reg[QAW-1:0] == (wr_ptr_reg - rd_ptr_reg)))
        else $error("command queue count mismatch");

endmodule

// ===== rtl/core/vrd_back.sv =====
// result stage: forms the byte address and holds the output beat
module vrd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  vrd_pkg::vrd_cmd_t cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        event_res,
    output logic [1:0]        record_class,
    output logic [7:0]        out_byte,
    output logic [31:0]       byte_address,
    output logic              record_end,
    output logic [15:0]       payload_length
);
    import vrd_pkg::*;

    logic        valid_reg;
    logic [2:0]  ev_reg;
    logic [1:0]  cls_reg;
    logic [7:0]  data_reg;
    logic [31:0] addr_reg;
    logic        end_reg;
    logic [15:0] plen_reg;

    // take the queue head whenever the output register is free or draining
    assign pop = cmd_valid && (!valid_reg || out_ready);

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // output payload, address is base plus payload index
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ev_reg   <= cmd.ev;
            cls_reg  <= cmd.cls;
            data_reg <= cmd.data;
            addr_reg <= cmd.base + {16'h0000, cmd.offset};
            end_reg  <= cmd.rec_end;
            plen_reg <= cmd.plen;
        end
    end

    assign out_valid      = valid_reg;
    assign event_res      = ev_reg;
    assign record_class   = cls_reg;
    assign out_byte       = data_reg;
    assign byte_address   = addr_reg;
    assign record_end     = end_reg;
    assign payload_length = plen_reg;

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the object stream record deframer
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vrd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_BEATS = 140;
    localparam int HOLD_CYCLES = 60;

    // one result beat, laid out in port order
    typedef struct packed {
        logic [2:0]  ev;
        logic [1:0]  cls;
        logic [7:0]  data;
        logic [31:0] addr;
        logic        rec_end;
        logic [15:0] plen;
    } deframe_res_t;

    // framing predictor and store of expected result beats
    class deframe_scoreboard;
        logic [15:0]  length_limit;
        logic [1:0]   phase;
        logic [15:0]  rec_len;
        logic [15:0]  body_count;
        logic [7:0]   rec_type;
        logic [31:0]  load_addr;
        bit           skipping;
        deframe_res_t expected_q[$];
        int           errors;

        function new();
            length_limit = 16'hFFFF;
            phase        = PH_LEN_LO;
            rec_len      = '0;
            body_count   = '0;
            rec_type     = '0;
            load_addr    = '0;
            skipping     = 1'b0;
            errors       = 0;
        endfunction

        function void set_limit(logic [15:0] v);
            length_limit = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // advance the framing state by one accepted input beat
        function void note_beat(logic [7:0] b, logic eoi);
            deframe_res_t r;
            logic [15:0]  idx;
            logic [1:0]   cls;
            bit           last;
            bit           emit;
            r = '0;
            emit = 1'b0;

            // end of input: clean between records, truncated anywhere else
            if (eoi)
            begin
                r.ev = (phase == PH_LEN_LO) ? EV_EOS : EV_TRUNC;
                phase = PH_LEN_LO;
                skipping = 1'b0;
                body_count = '0;
                expected_q.push_back(r);
                return;
            end

            case (phase)
                PH_LEN_LO:
                begin
                    rec_len = {8'h00, b};
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    rec_len[15:8] = b;
                    body_count = '0;
                    rec_type = '0;
                    load_addr = '0;
                    if (rec_len == 16'd0)
                    begin
                        // empty record ends at once
                        phase = PH_LEN_LO;
                        r.ev = EV_END;
                        r.cls = CL_UNKNOWN;
                        r.rec_end = 1'b1;
                        expected_q.push_back(r);
                    end
                    else
                    begin
                        phase = PH_BODY;
                        skipping = (rec_len > length_limit);
                        if (skipping)
                        begin
                            r.ev = EV_OVER;
                            expected_q.push_back(r);
                        end
                    end
                end
                PH_PAD:
                begin
                    phase = PH_LEN_LO;
                end
                default:
                begin
                    // record body
                    idx = body_count;
                    body_count = body_count + 16'd1;
                    last = (body_count >= rec_len);
                    if (!skipping)
                    begin
                        if (idx == 16'd0)
                        begin
                            rec_type = b;
                        end
                        else if (rec_type == TYPE_DATA)
                        begin
                            if (rec_len >= DATA_HEAD)
                            begin
                                if (idx < DATA_HEAD)
                                begin
                                    load_addr[8*(idx-1) +: 8] = b;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                    r.addr = load_addr + 32'(idx - DATA_HEAD);
                                end
                            end
                        end
                        else if (rec_type == TYPE_TRANS)
                        begin
                            emit = 1'b1;
                        end
                    end
                    if (emit)
                    begin
                        r.ev = EV_BYTE;
                        r.data = b;
                    end
                    if (last)
                    begin
                        if (!skipping)
                        begin
                            if (rec_type == TYPE_DATA)
                                cls = (rec_len >= DATA_HEAD) ? CL_DATA : CL_SHORT;
                            else if (rec_type == TYPE_TRANS)
                                cls = CL_TRANS;
                            else
                                cls = CL_UNKNOWN;
                            if (!emit)
                                r.ev = EV_END;
                            r.cls = cls;
                            r.rec_end = 1'b1;
                            if (cls == CL_DATA)
                                r.plen = rec_len - DATA_HEAD;
                            else if (cls == CL_SHORT)
                                r.plen = 16'd0;
                            else
                                r.plen = rec_len - 16'd1;
                            emit = 1'b1;
                        end
                        skipping = 1'b0;
                        phase = rec_len[0] ? PH_PAD : PH_LEN_LO;
                    end
                    if (emit)
                        expected_q.push_back(r);
                end
            endcase
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h",
                         $time, name, want, got);
            end
        endfunction

        // compare one output beat against the oldest expectation
        function void check_result(deframe_res_t got);
            deframe_res_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none actual %h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            report_field("event_res", want.ev, got.ev);
            report_field("record_class", want.cls, got.cls);
            report_field("out_byte", want.data, got.data);
            report_field("byte_address", want.addr, got.addr);
            report_field("record_end", want.rec_end, got.rec_end);
            report_field("payload_length", want.plen, got.plen);
        endfunction
    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [15:0] cfg_write_data = '0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte        = '0;
    logic        end_of_input   = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [2:0]  event_res;
    logic [1:0]  record_class;
    logic [7:0]  out_byte;
    logic [31:0] byte_address;
    logic        record_end;
    logic [15:0] payload_length;

    deframe_scoreboard sb;
    bit          idle_on  = 1'b0;
    bit          stall_on = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned beats_sent = 0;
    int          quiet_cycles = 0;
    logic [15:0] limit_table [5];

    vlda_record_deframer_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .end_of_input   (end_of_input),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .record_class   (record_class),
        .out_byte       (out_byte),
        .byte_address   (byte_address),
        .record_end     (record_end),
        .payload_length (payload_length)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one input beat and wait until it is taken
    task automatic send_beat(input logic [7:0] b, input logic eoi);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_beat(b, eoi);
        beats_sent++;
    endtask

    // one framed record: length, type, body, pad; end of input at beat 'cut'
    task automatic send_frame(input int unsigned len, input logic [7:0] kind,
                              input bit top_addr, input int cut);
        int unsigned total;
        logic [7:0]  b;
        total = 2 + len + (len & 1);
        for (int k = 0; k < total; k++)
        begin
            if (k == cut)
            begin
                send_beat(8'($urandom), 1'b1);
                return;
            end
            b = 8'($urandom);
            if (k == 0)
                b = len[7:0];
            else if (k == 1)
                b = len[15:8];
            else if (k == 2)
                b = kind;
            else if (top_addr && kind == TYPE_DATA && k < 7)
                b = 8'hFF;
            send_beat(b, 1'b0);
        end
    endtask

    // mostly well-formed records, some stream ends and some junk
    task automatic random_record();
        int unsigned sel;
        int unsigned len;
        logic [7:0]  kind;
        int          cut;
        sel = $urandom_range(0, 99);
        if (sel < 4)
        begin
            send_beat(8'($urandom), 1'b1);
        end
        else if (sel < 8)
        begin
            repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 1'b0);
            send_beat(8'($urandom), 1'b1);
        end
        else
        begin
            sel = $urandom_range(0, 9);
            kind = (sel < 4) ? TYPE_DATA : (sel < 7) ? TYPE_TRANS : 8'($urandom);
            sel = $urandom_range(0, 19);
            cut = -1;
            if (sel == 0)
            begin
                // huge length, always cut short by end of input
                len = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(300, 65535);
                cut = $urandom_range(0, 30);
            end
            else
            begin
                len = (sel < 3) ? $urandom_range(21, 200) : $urandom_range(0, 20);
                if ($urandom_range(0, 9) == 0)
                    cut = $urandom_range(0, len + 2);
            end
            send_frame(len, kind, $urandom_range(0, 3) == 0, cut);
        end
    endtask

    // stop offering and let every expected beat come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.set_limit(v);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        deframe_res_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {event_res, record_class, out_byte, byte_address,
                    record_end, payload_length};
            sb.check_result(seen);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        int unsigned goal;
        sb = new();
        limit_table = '{16'hFFFF, 16'h0000, DATA_HEAD,
                        16'($urandom_range(1, 300)), 16'hFFFF};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_limit(limit_table[0]);

        // directed: empty record, stream end, short data with pad,
        // address wrap, transparent, end of input in body and in length
        send_frame(0, TYPE_DATA, 1'b0, -1);
        send_beat(8'hFF, 1'b1);
        send_frame(1, TYPE_DATA, 1'b0, -1);
        send_frame(7, TYPE_DATA, 1'b1, -1);
        send_frame(2, TYPE_TRANS, 1'b0, -1);
        send_frame(3, TYPE_TRANS, 1'b0, 3);
        send_frame(9, TYPE_DATA, 1'b0, 1);

        // random phases under a series of length limits
        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
            begin
                drain_results();
                write_limit(limit_table[p]);
            end
            if (p == 0)
            begin
                // receiver holds off while a long transparent record streams in
                idle_on  = 1'b0;
                stall_on = 1'b0;
                hold_req = 1'b1;
                send_frame(60, TYPE_TRANS, 1'b0, -1);
            end
            goal = beats_sent + PHASE_BEATS;
            while (beats_sent < goal)
            begin
                idle_on  = (p < 4) && ($urandom_range(0, 3) != 0);
                stall_on = (p < 4) && ($urandom_range(0, 3) != 0);
                random_record();
            end
        end
        drain_results();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== vlda_record_deframer_unit.f =====
rtl/core/vrd_pkg.sv
rtl/core/vrd_front.sv
rtl/core/vrd_queue.sv
rtl/core/vrd_back.sv
rtl/core/vlda_record_deframer_unit.sv
bench/tb.sv
